@@ src/rfs_pkg.sv @@
// Package for the ranging frame supervisor: event item layout, status codes,
// configuration indexes and block constants. No dependencies.
`default_nettype none

package rfs_pkg;

	// Number of zones the sensor reports; zones at or above this are never valid.
	localparam int MAX_ZONES = 64;

	localparam logic [7:0] TSTAT_VALID_A = 8'd5;
	localparam logic [7:0] TSTAT_VALID_B = 8'd9;
	localparam logic [7:0] ZONE_NONE     = 8'hFF;
	localparam logic signed [15:0] DIST_NONE = -16'sd1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS  = 1'd1;

	localparam logic [15:0] STALE_LIMIT_RST = 16'd500;
	localparam logic [7:0]  MAX_ERRORS_RST  = 8'd3;

	typedef enum logic [2:0] {
		OP_ZONE       = 3'd0,
		OP_BUS_ERR    = 3'd1,
		OP_POLL       = 3'd2,
		OP_START_OK   = 3'd3,
		OP_START_FAIL = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_UNINIT  = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_ERROR   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_NOT_FOUND = 3'd1,
		ERR_INIT      = 3'd2,
		ERR_CONFIG    = 3'd3,
		ERR_START     = 3'd4,
		ERR_BUS       = 3'd5,
		ERR_STALE     = 3'd6
	} err_t;

	// One input event.
	typedef struct packed {
		logic [2:0]         op;
		logic [31:0]        now_ms;
		logic [5:0]         zone_index;
		logic signed [15:0] range_mm;
		logic [7:0]         target_status_code;
		logic [7:0]         target_count;
		logic               last_zone;
		logic [1:0]         fail_code;
		logic [7:0]         drv_status;
	} item_t;

	// One status result.
	typedef struct packed {
		logic [1:0]         run_state;
		logic [2:0]         err_code;
		logic [7:0]         last_api_code;
		logic               frame_done;
		logic [31:0]        frame_count;
		logic [63:0]        zone_mask;
		logic signed [15:0] min_distance;
		logic [7:0]         near_zone;
		logic [31:0]        fail_total;
		logic [31:0]        bus_error_count;
	} result_t;

	// Handshake between input stage and update engine.
	typedef struct packed {
		logic adv;     // engine takes the held item this cycle
	} stage_ctl_t;

endpackage

`default_nettype wire

@@ src/rfs_in_stage.sv @@
// Input register stage of the ranging frame supervisor.
// Holds one accepted event; depends on rfs_pkg.
`default_nettype none

module rfs_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire rfs_pkg::item_t item,
	input  wire logic          adv,
	output rfs_pkg::item_t     item_s1,
	output logic               valid_s1
);

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

@@ src/rfs_engine.sv @@
// Update engine of the ranging frame supervisor: supervisor state, frame
// accumulation and the result register. Depends on rfs_pkg.
`default_nettype none

module rfs_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rfs_pkg::item_t      item_s1,
	input  wire logic                valid_s1,
	output rfs_pkg::stage_ctl_t      ctl,
	input  wire logic [15:0]         stale_limit,
	input  wire logic [7:0]          max_errors,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rfs_pkg::result_t         res
);

	rfs_pkg::mode_t     mode_q, mode_d;
	rfs_pkg::err_t      err_q, err_d;
	logic [7:0]         api_q, api_d;
	logic [7:0]         cons_q, cons_d;
	logic [31:0]        lft_q, lft_d;
	logic [31:0]        frames_q, frames_d;
	logic [63:0]        mask_q, mask_d;
	logic signed [15:0] best_dist_q, best_dist_d;
	logic [7:0]         best_zone_q, best_zone_d;
	logic [31:0]        fails_q, fails_d;
	logic [31:0]        bus_q, bus_d;
	logic               done_q, done_d;
	logic               out_valid_q;
	logic               fire;

	// Combinational scratch
	logic               running;
	logic               zone_ok;
	logic               fail;
	rfs_pkg::err_t      fail_kind;
	logic [7:0]         fail_api;
	logic [63:0]        mask_base;
	logic signed [15:0] best_base;
	logic [7:0]         best_zone_base;
	logic [7:0]         cons_inc;
	logic [31:0]        age;

	assign ctl.adv   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && ctl.adv;

	assign running = (mode_q == rfs_pkg::MODE_RUNNING);
	assign zone_ok = ({1'b0, item_s1.zone_index} < 7'(rfs_pkg::MAX_ZONES))
		&& (item_s1.target_count != 8'd0)
		&& (item_s1.target_status_code == rfs_pkg::TSTAT_VALID_A
			|| item_s1.target_status_code == rfs_pkg::TSTAT_VALID_B)
		&& !item_s1.range_mm[15] && (item_s1.range_mm != 16'sd0);
	assign cons_inc = (cons_q == 8'hFF) ? cons_q : cons_q + 8'd1;
	assign age      = item_s1.now_ms - lft_q;

	always_comb begin
		mode_d      = mode_q;
		err_d       = err_q;
		api_d       = api_q;
		cons_d      = cons_q;
		lft_d       = lft_q;
		frames_d    = frames_q;
		mask_d      = mask_q;
		best_dist_d = best_dist_q;
		best_zone_d = best_zone_q;
		fails_d     = fails_q;
		bus_d       = bus_q;
		done_d      = 1'b0;
		fail        = 1'b0;
		fail_kind   = rfs_pkg::ERR_NONE;
		fail_api    = 8'd0;

		// Zone 0 opens a new frame from a cleared accumulator.
		if (item_s1.zone_index == 6'd0) begin
			mask_base      = '0;
			best_base      = rfs_pkg::DIST_NONE;
			best_zone_base = rfs_pkg::ZONE_NONE;
		end else begin
			mask_base      = mask_q;
			best_base      = best_dist_q;
			best_zone_base = best_zone_q;
		end

		case (rfs_pkg::op_t'(item_s1.op))
			rfs_pkg::OP_ZONE: begin
				if (running) begin
					mask_d      = mask_base;
					best_dist_d = best_base;
					best_zone_d = best_zone_base;
					if (item_s1.zone_index == 6'd0) begin
						lft_d  = item_s1.now_ms;
						cons_d = 8'd0;
					end
					if (zone_ok) begin
						mask_d = mask_base | (64'd1 << item_s1.zone_index);
						// strict compare keeps the earlier zone on a tie
						if (best_base[15] || (item_s1.range_mm < best_base)) begin
							best_dist_d = item_s1.range_mm;
							best_zone_d = {2'b00, item_s1.zone_index};
						end
					end
					if (item_s1.last_zone) begin
						frames_d = frames_q + 32'd1;
						done_d   = 1'b1;
					end
				end
			end
			rfs_pkg::OP_BUS_ERR: begin
				if (running) begin
					bus_d  = bus_q + 32'd1;
					cons_d = cons_inc;
					if (cons_inc >= max_errors) begin
						fail      = 1'b1;
						fail_kind = rfs_pkg::ERR_BUS;
						fail_api  = item_s1.drv_status;
					end
				end
			end
			rfs_pkg::OP_POLL: begin
				if (running && (age > {16'd0, stale_limit})) begin
					fail      = 1'b1;
					fail_kind = rfs_pkg::ERR_STALE;
				end
			end
			rfs_pkg::OP_START_OK: begin
				mode_d = rfs_pkg::MODE_RUNNING;
				err_d  = rfs_pkg::ERR_NONE;
				cons_d = 8'd0;
				lft_d  = item_s1.now_ms;
			end
			rfs_pkg::OP_START_FAIL: begin
				cons_d    = 8'd0;
				fail      = 1'b1;
				fail_kind = rfs_pkg::err_t'({1'b0, item_s1.fail_code} + 3'd1);
				fail_api  = item_s1.drv_status;
			end
			default: begin
			end
		endcase

		if (fail) begin
			mode_d  = rfs_pkg::MODE_ERROR;
			err_d   = fail_kind;
			api_d   = fail_api;
			fails_d = fails_q + 32'd1;
		end
	end

	// State only moves when an item is processed; the state registers
	// then double as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= rfs_pkg::MODE_UNINIT;
			err_q       <= rfs_pkg::ERR_NONE;
			api_q       <= 8'd0;
			cons_q      <= 8'd0;
			lft_q       <= 32'd0;
			frames_q    <= 32'd0;
			mask_q      <= 64'd0;
			best_dist_q <= rfs_pkg::DIST_NONE;
			best_zone_q <= rfs_pkg::ZONE_NONE;
			fails_q     <= 32'd0;
			bus_q       <= 32'd0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				mode_q      <= mode_d;
				err_q       <= err_d;
				api_q       <= api_d;
				cons_q      <= cons_d;
				lft_q       <= lft_d;
				frames_q    <= frames_d;
				mask_q      <= mask_d;
				best_dist_q <= best_dist_d;
				best_zone_q <= best_zone_d;
				fails_q     <= fails_d;
				bus_q       <= bus_d;
				done_q      <= done_d;
			end
			if (ctl.adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign res.run_state       = mode_q;
	assign res.err_code        = err_q;
	assign res.last_api_code   = api_q;
	assign res.frame_done      = done_q;
	assign res.frame_count     = frames_q;
	assign res.zone_mask       = mask_q;
	assign res.min_distance    = best_dist_q;
	assign res.near_zone       = best_zone_q;
	assign res.fail_total      = fails_q;
	assign res.bus_error_count = bus_q;

`ifndef SYNTHESIS
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item_s1.op == rfs_pkg::OP_START_OK) |=> mode_q == rfs_pkg::MODE_RUNNING)
		else $error("start ok did not enter running");
	a_done_running: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> mode_q == rfs_pkg::MODE_RUNNING)
		else $error("frame completed outside running");
	a_none_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(best_zone_q == rfs_pkg::ZONE_NONE) == (best_dist_q == rfs_pkg::DIST_NONE))
		else $error("minimum distance and zone disagree");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(bus_q) && $stable(fails_q) && $stable(frames_q))
		else $error("counters moved without a processed item");
`endif

endmodule

`default_nettype wire

@@ src/ranging_frame_supervisor.sv @@
// Ranging frame supervisor top level: ports, configuration registers and
// the two pipeline parts. Depends on rfs_pkg, rfs_in_stage, rfs_engine.
//
// Usage:
//  - Events enter on the in channel (in_valid/in_ready); one transfer moves
//    one event (op plus its fields). Each event yields exactly one status
//    transfer on the out channel (out_valid/out_ready).
//  - An event is first held in the input register; the engine then processes
//    it into the state registers, which show its status until it is taken.
//  - Throughput: one event per cycle while the receiver keeps out_ready high;
//    the single update engine does all state changes for an event at once.
//  - A stalled receiver holds the status register; one more event is still
//    taken into the input register, after which in_ready drops.
//  - Reset (arst_n low) clears everything: uninitialised mode, no error,
//    counters zero, no minimum (-1 / zone 255), stale limit 500 ms, bus error
//    limit 3. No clearing pass is needed; events are taken right after reset.
//  - Configuration: cfg_we, cfg_idx (0 stale limit, 1 error limit), cfg_wdata,
//    written at once. Write only while no event is in flight (not checked).
`default_nettype none

module ranging_frame_supervisor (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rfs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [rfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [2:0]                      op,
	input  wire logic [31:0]                     now_ms,
	input  wire logic [5:0]                      zone_index,
	input  wire logic signed [15:0]              range_mm,
	input  wire logic [7:0]                      target_status_code,
	input  wire logic [7:0]                      target_count,
	input  wire logic                            last_zone,
	input  wire logic [1:0]                      fail_code,
	input  wire logic [7:0]                      drv_status,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           run_state,
	output logic [2:0]                           err_code,
	output logic [7:0]                           last_api_code,
	output logic                                 frame_done,
	output logic [31:0]                          frame_count,
	output logic [63:0]                          zone_mask,
	output logic signed [15:0]                   min_distance,
	output logic [7:0]                           near_zone,
	output logic [31:0]                          fail_total,
	output logic [31:0]                          bus_error_count
);

	logic [15:0]         stale_limit_q;
	logic [7:0]          max_errors_q;
	rfs_pkg::item_t      item;
	rfs_pkg::item_t      item_s1;
	logic                valid_s1;
	rfs_pkg::stage_ctl_t ctl;
	rfs_pkg::result_t    res;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= rfs_pkg::STALE_LIMIT_RST;
			max_errors_q  <= rfs_pkg::MAX_ERRORS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				rfs_pkg::CFG_STALE_LIMIT: stale_limit_q <= cfg_wdata;
				rfs_pkg::CFG_MAX_ERRORS:  max_errors_q  <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign item.op                 = op;
	assign item.now_ms             = now_ms;
	assign item.zone_index         = zone_index;
	assign item.range_mm           = range_mm;
	assign item.target_status_code = target_status_code;
	assign item.target_count       = target_count;
	assign item.last_zone          = last_zone;
	assign item.fail_code          = fail_code;
	assign item.drv_status         = drv_status;

	// Input register: frees up as soon as the engine takes its item.
	rfs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.adv      (ctl.adv),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	// Engine: one event per cycle unless stalled; state registers are the output.
	rfs_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_s1     (item_s1),
		.valid_s1    (valid_s1),
		.ctl         (ctl),
		.stale_limit (stale_limit_q),
		.max_errors  (max_errors_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res)
	);

	assign run_state       = res.run_state;
	assign err_code        = res.err_code;
	assign last_api_code   = res.last_api_code;
	assign frame_done      = res.frame_done;
	assign frame_count     = res.frame_count;
	assign zone_mask       = res.zone_mask;
	assign min_distance    = res.min_distance;
	assign near_zone       = res.near_zone;
	assign fail_total      = res.fail_total;
	assign bus_error_count = res.bus_error_count;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for ranging_frame_supervisor: a directed table, then random event
// streams under several register settings, all checked against a local model.
// Depends on rfs_pkg and the ranging_frame_supervisor RTL.
`timescale 1ns / 1ps

module tb_top;

	// op codes 5..7 are not decoded by the block; they only report status
	localparam logic [2:0] OP_UNUSED = 3'd5;
	localparam logic [7:0] CONSEC_MAX = 8'hFF;
	// cycles with no transfer on either channel before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 300;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_idx;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         op;
	logic [31:0]        now_ms;
	logic [5:0]         zone_index;
	logic signed [15:0] range_mm;
	logic [7:0]         target_status_code;
	logic [7:0]         target_count;
	logic               last_zone;
	logic [1:0]         fail_code;
	logic [7:0]         drv_status;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         run_state;
	logic [2:0]         err_code;
	logic [7:0]         last_api_code;
	logic               frame_done;
	logic [31:0]        frame_count;
	logic [63:0]        zone_mask;
	logic signed [15:0] min_distance;
	logic [7:0]         near_zone;
	logic [31:0]        fail_total;
	logic [31:0]        bus_error_count;

	ranging_frame_supervisor dut (.*);

	always #2 clk = ~clk;

	// One row of the directed table: either a register write or an event.
	// A pinned row carries a hand-typed state/error/api code that overrides
	// the model for those three fields.
	typedef struct {
		bit              is_cfg;
		logic [0:0]      idx;
		logic [15:0]     data;
		rfs_pkg::item_t  ev;
		bit              pinned;
		rfs_pkg::mode_t  st;
		rfs_pkg::err_t   er;
		logic [7:0]      api;
	} vec_t;

	vec_t             dir_tab[$];
	rfs_pkg::result_t pending_status[$];
	rfs_pkg::result_t want_status;
	int      mismatch_cnt = 0;
	int      applied_cnt = 0;
	int      idle_cycles = 0;
	bit      tx_burst = 0;
	bit      rx_burst = 0;
	logic [31:0] tick;

	// ---- supervisor model state ----
	rfs_pkg::mode_t     st_mode;
	rfs_pkg::err_t      st_err;
	logic [7:0]         st_api;
	logic [7:0]         st_consec;
	logic [31:0]        st_frame_time;
	logic [31:0]        st_frames;
	logic [63:0]        st_mask;
	logic signed [15:0] st_best_dist;
	logic [7:0]         st_best_zone;
	logic [31:0]        st_fail_cnt;
	logic [31:0]        st_bus_cnt;
	logic [15:0]        cfg_stale;
	logic [7:0]         cfg_max_err;

	function automatic void log_failure(rfs_pkg::err_t kind, logic [7:0] api);
		st_mode = rfs_pkg::MODE_ERROR;
		st_err = kind;
		st_api = api;
		st_fail_cnt = st_fail_cnt + 32'd1;
	endfunction

	// Applies one event to the model and returns the status it should report.
	function automatic rfs_pkg::result_t supervise_event(rfs_pkg::item_t ev);
		rfs_pkg::result_t r;
		logic             done;
		done = 1'b0;
		case (ev.op)
			rfs_pkg::OP_ZONE: begin
				if (st_mode == rfs_pkg::MODE_RUNNING) begin
					// zone 0 opens a new frame
					if (ev.zone_index == 6'd0) begin
						st_mask = '0;
						st_best_dist = rfs_pkg::DIST_NONE;
						st_best_zone = rfs_pkg::ZONE_NONE;
						st_frame_time = ev.now_ms;
						st_consec = '0;
					end
					if (int'(ev.zone_index) < rfs_pkg::MAX_ZONES && ev.target_count != 8'd0 &&
							(ev.target_status_code == rfs_pkg::TSTAT_VALID_A ||
							ev.target_status_code == rfs_pkg::TSTAT_VALID_B) &&
							ev.range_mm > 0) begin
						st_mask[ev.zone_index] = 1'b1;
						// strict less-than: a tie keeps the earlier zone
						if (st_best_dist < 0 || ev.range_mm < st_best_dist) begin
							st_best_dist = ev.range_mm;
							st_best_zone = {2'b00, ev.zone_index};
						end
					end
					if (ev.last_zone) begin
						st_frames = st_frames + 32'd1;
						done = 1'b1;
					end
				end
			end
			rfs_pkg::OP_BUS_ERR: begin
				if (st_mode == rfs_pkg::MODE_RUNNING) begin
					st_bus_cnt = st_bus_cnt + 32'd1;
					if (st_consec != CONSEC_MAX)
						st_consec = st_consec + 8'd1;
					if (st_consec >= cfg_max_err)
						log_failure(rfs_pkg::ERR_BUS, ev.drv_status);
				end
			end
			rfs_pkg::OP_POLL: begin
				if (st_mode == rfs_pkg::MODE_RUNNING &&
						(ev.now_ms - st_frame_time) > {16'h0000, cfg_stale})
					log_failure(rfs_pkg::ERR_STALE, 8'h00);
			end
			rfs_pkg::OP_START_OK: begin
				st_mode = rfs_pkg::MODE_RUNNING;
				st_err = rfs_pkg::ERR_NONE;
				st_consec = '0;
				st_frame_time = ev.now_ms;
			end
			rfs_pkg::OP_START_FAIL: begin
				st_consec = '0;
				log_failure(rfs_pkg::err_t'({1'b0, ev.fail_code} + 3'd1), ev.drv_status);
			end
			default: ;
		endcase
		r.run_state = st_mode;
		r.err_code = st_err;
		r.last_api_code = st_api;
		r.frame_done = done;
		r.frame_count = st_frames;
		r.zone_mask = st_mask;
		r.min_distance = st_best_dist;
		r.near_zone = st_best_zone;
		r.fail_total = st_fail_cnt;
		r.bus_error_count = st_bus_cnt;
		return r;
	endfunction

	// ---- stimulus helpers ----
	function automatic rfs_pkg::item_t rand_item();
		rfs_pkg::item_t v;
		v.op = 3'($urandom);
		v.now_ms = $urandom;
		v.zone_index = 6'($urandom);
		v.range_mm = 16'($urandom);
		v.target_status_code = 8'($urandom);
		v.target_count = 8'($urandom);
		v.last_zone = 1'($urandom);
		v.fail_code = 2'($urandom);
		v.drv_status = 8'($urandom);
		return v;
	endfunction

	// Millisecond clock: small steps, now and then a large jump (wraps freely).
	function automatic logic [31:0] next_tick();
		if ($urandom_range(0, 199) == 0)
			tick = tick + $urandom;
		else
			tick = tick + $urandom_range(0, 5);
		return tick;
	endfunction

	// Mostly valid targets, with ties on small distances and all the reasons
	// for a zone to be rejected mixed in.
	function automatic rfs_pkg::item_t zone_sample(logic [5:0] z, logic lz);
		rfs_pkg::item_t v;
		v = rand_item();
		v.op = rfs_pkg::OP_ZONE;
		v.now_ms = next_tick();
		v.zone_index = z;
		v.last_zone = lz;
		v.target_count = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v.target_status_code = rfs_pkg::TSTAT_VALID_A;
			4, 5, 6:    v.target_status_code = rfs_pkg::TSTAT_VALID_B;
			default:    v.target_status_code = 8'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v.range_mm = 16'($urandom_range(1, 4000));
			5, 6:          v.range_mm = 16'($urandom_range(1, 4));
			7:             v.range_mm = $urandom_range(0, 1) ? 16'sd32767 : 16'sd1;
			default:       v.range_mm = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic vec_t ev_row(logic [2:0] o, logic [31:0] t, logic [5:0] z,
			logic signed [15:0] d, logic [7:0] ts, logic [7:0] tc, logic lz,
			logic [1:0] fc, logic [7:0] ap);
		vec_t v;
		v.is_cfg = 1'b0;
		v.idx = '0;
		v.data = '0;
		v.pinned = 1'b0;
		v.st = rfs_pkg::MODE_UNINIT;
		v.er = rfs_pkg::ERR_NONE;
		v.api = '0;
		v.ev.op = o;
		v.ev.now_ms = t;
		v.ev.zone_index = z;
		v.ev.range_mm = d;
		v.ev.target_status_code = ts;
		v.ev.target_count = tc;
		v.ev.last_zone = lz;
		v.ev.fail_code = fc;
		v.ev.drv_status = ap;
		return v;
	endfunction

	function automatic vec_t pin(vec_t v, rfs_pkg::mode_t m, rfs_pkg::err_t e,
			logic [7:0] ap);
		v.pinned = 1'b1;
		v.st = m;
		v.er = e;
		v.api = ap;
		return v;
	endfunction

	function automatic vec_t cfg_row(logic [0:0] i, logic [15:0] d);
		vec_t v;
		v = ev_row(OP_UNUSED, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		v.is_cfg = 1'b1;
		v.idx = i;
		v.data = d;
		return v;
	endfunction

	// Presents one event after a random gap and holds it until the transfer.
	// The expected status is queued at the transfer edge.
	task automatic send_event(rfs_pkg::item_t ev, bit pinned = 1'b0,
			rfs_pkg::mode_t m = rfs_pkg::MODE_UNINIT,
			rfs_pkg::err_t e = rfs_pkg::ERR_NONE, logic [7:0] ap = 8'h00);
		int               gap;
		bit               acted;
		rfs_pkg::result_t r;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 49) == 0)
			tx_burst = !tx_burst;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op = ev.op;
		now_ms = ev.now_ms;
		zone_index = ev.zone_index;
		range_mm = ev.range_mm;
		target_status_code = ev.target_status_code;
		target_count = ev.target_count;
		last_zone = ev.last_zone;
		fail_code = ev.fail_code;
		drv_status = ev.drv_status;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// events dropped outside the running state do not count toward a phase
		acted = (ev.op == rfs_pkg::OP_START_OK || ev.op == rfs_pkg::OP_START_FAIL) ||
			(ev.op <= rfs_pkg::OP_POLL && st_mode == rfs_pkg::MODE_RUNNING);
		r = supervise_event(ev);
		if (pinned) begin
			r.run_state = m;
			r.err_code = e;
			r.last_api_code = ap;
		end
		pending_status.push_back(r);
		if (acted)
			applied_cnt++;
	endtask

	// Drops valid and drains every outstanding status; every event yields a
	// status, so an empty queue means the block is idle.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] i, logic [15:0] d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = i;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
		if (i == rfs_pkg::CFG_STALE_LIMIT)
			cfg_stale = d;
		else
			cfg_max_err = d[7:0];
	endtask

	// Random traffic, mostly complete frames from a running sensor, with
	// bus error bursts, polls near the stale threshold, restarts and noise.
	task automatic run_phase(int quota);
		int             goal;
		int             pick;
		int             len;
		rfs_pkg::item_t ev;
		goal = applied_cnt + quota;
		while (applied_cnt < goal) begin
			pick = $urandom_range(0, 99);
			if (st_mode != rfs_pkg::MODE_RUNNING && $urandom_range(0, 3) != 0) begin
				ev = rand_item();
				ev.op = rfs_pkg::OP_START_OK;
				ev.now_ms = next_tick();
				send_event(ev);
			end else if (pick < 50) begin
				len = ($urandom_range(0, 9) == 0) ? rfs_pkg::MAX_ZONES :
					$urandom_range(1, 12);
				for (int z = 0; z < len; z++)
					send_event(zone_sample(6'(z), z == len - 1));
			end else if (pick < 62) begin
				// sometimes a burst long enough to hit the error limit
				len = ($urandom_range(0, 7) == 0) ? int'(cfg_max_err) + 1 : $urandom_range(1, 4);
				for (int k = 0; k < len; k++) begin
					ev = rand_item();
					ev.op = rfs_pkg::OP_BUS_ERR;
					ev.now_ms = next_tick();
					send_event(ev);
				end
			end else if (pick < 74) begin
				len = $urandom_range(1, 3);
				for (int k = 0; k < len; k++) begin
					ev = rand_item();
					ev.op = rfs_pkg::OP_POLL;
					if ($urandom_range(0, 3) == 0)
						ev.now_ms = next_tick();
					else
						ev.now_ms = st_frame_time + {16'h0000, cfg_stale} +
							32'($urandom_range(0, 4)) - 32'd2;
					send_event(ev);
				end
			end else if (pick < 80) begin
				ev = rand_item();
				ev.op = rfs_pkg::OP_START_OK;
				ev.now_ms = next_tick();
				send_event(ev);
			end else if (pick < 85) begin
				ev = rand_item();
				ev.op = rfs_pkg::OP_START_FAIL;
				send_event(ev);
			end else if (pick < 95) begin
				send_event(rand_item());
			end else begin
				// broken frame: zones out of order, stray last marks
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_event(zone_sample(6'($urandom), 1'($urandom)));
			end
		end
	endtask

	// ---- receiver: random stalls, with stretches of none ----
	initial begin
		int w;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = rx_burst ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 49) == 0)
				rx_burst = !rx_burst;
			@(negedge clk);
			if (w > 0) begin
				out_ready = 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// ---- status checker: each status transfer against the oldest expectation ----
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				$error("status transfer with no event outstanding");
				mismatch_cnt++;
			end else begin
				want_status = pending_status.pop_front();
				if (run_state !== want_status.run_state) begin
					$error("run_state: expected %0d, got %0d", want_status.run_state, run_state);
					mismatch_cnt++;
				end
				if (err_code !== want_status.err_code) begin
					$error("err_code: expected %0d, got %0d", want_status.err_code, err_code);
					mismatch_cnt++;
				end
				if (last_api_code !== want_status.last_api_code) begin
					$error("last_api_code: expected %0h, got %0h",
						want_status.last_api_code, last_api_code);
					mismatch_cnt++;
				end
				if (frame_done !== want_status.frame_done) begin
					$error("frame_done: expected %0d, got %0d", want_status.frame_done, frame_done);
					mismatch_cnt++;
				end
				if (frame_count !== want_status.frame_count) begin
					$error("frame_count: expected %0d, got %0d",
						want_status.frame_count, frame_count);
					mismatch_cnt++;
				end
				if (zone_mask !== want_status.zone_mask) begin
					$error("zone_mask: expected %h, got %h", want_status.zone_mask, zone_mask);
					mismatch_cnt++;
				end
				if (min_distance !== want_status.min_distance) begin
					$error("min_distance: expected %0d, got %0d",
						want_status.min_distance, min_distance);
					mismatch_cnt++;
				end
				if (near_zone !== want_status.near_zone) begin
					$error("near_zone: expected %0d, got %0d", want_status.near_zone, near_zone);
					mismatch_cnt++;
				end
				if (fail_total !== want_status.fail_total) begin
					$error("fail_total: expected %0d, got %0d",
						want_status.fail_total, fail_total);
					mismatch_cnt++;
				end
				if (bus_error_count !== want_status.bus_error_count) begin
					$error("bus_error_count: expected %0d, got %0d",
						want_status.bus_error_count, bus_error_count);
					mismatch_cnt++;
				end
			end
		end
	end

	// ---- watchdog: any transfer on either channel restarts the count ----
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---- main sequence ----
	initial begin
		logic [15:0] stale_set[5];
		logic [15:0] err_set[5];

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = '0;
		now_ms = '0;
		zone_index = '0;
		range_mm = '0;
		target_status_code = '0;
		target_count = '0;
		last_zone = 1'b0;
		fail_code = '0;
		drv_status = '0;
		tick = $urandom;

		// model at reset
		st_mode = rfs_pkg::MODE_UNINIT;
		st_err = rfs_pkg::ERR_NONE;
		st_api = '0;
		st_consec = '0;
		st_frame_time = '0;
		st_frames = '0;
		st_mask = '0;
		st_best_dist = rfs_pkg::DIST_NONE;
		st_best_zone = rfs_pkg::ZONE_NONE;
		st_fail_cnt = '0;
		st_bus_cnt = '0;
		cfg_stale = rfs_pkg::STALE_LIMIT_RST;
		cfg_max_err = rfs_pkg::MAX_ERRORS_RST;

		// Directed table. Before any start, zone/bus/poll events and unused
		// ops are dropped; then both start outcomes, a frame with a tie, a
		// rejected zero and negative distance, a bad status, the highest zone,
		// the stale edge, the bus error limit, a zero limit and a wrapped clock.
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_ZONE, 32'd10, 6'd0, 16'sd100,
			rfs_pkg::TSTAT_VALID_A, 8'd1, 1'b1, 2'd0, 8'h00),
			rfs_pkg::MODE_UNINIT, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_BUS_ERR, 32'd11, 6'd0, 16'sd0, 8'd0, 8'd0,
			1'b0, 2'd0, 8'h5A), rfs_pkg::MODE_UNINIT, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_POLL, 32'hFFFF_FFFF, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h00), rfs_pkg::MODE_UNINIT, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(pin(ev_row(OP_UNUSED, 32'hFFFF_FFFF, 6'h3F, -16'sd1, 8'hFF, 8'hFF,
			1'b1, 2'd3, 8'hFF), rfs_pkg::MODE_UNINIT, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_START_FAIL, 32'd12, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'hFF), rfs_pkg::MODE_ERROR, rfs_pkg::ERR_NOT_FOUND, 8'hFF));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_START_FAIL, 32'd13, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd3, 8'h00), rfs_pkg::MODE_ERROR, rfs_pkg::ERR_START, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_START_OK, 32'd100, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h77), rfs_pkg::MODE_RUNNING, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_ZONE, 32'd200, 6'd0, 16'sd32767,
			rfs_pkg::TSTAT_VALID_A, 8'd255, 1'b0, 2'd0, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_ZONE, 32'd201, 6'd1, 16'sd1,
			rfs_pkg::TSTAT_VALID_B, 8'd1, 1'b0, 2'd0, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_ZONE, 32'd202, 6'd2, 16'sd1,
			rfs_pkg::TSTAT_VALID_A, 8'd1, 1'b0, 2'd0, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_ZONE, 32'd203, 6'd3, 16'sd0,
			rfs_pkg::TSTAT_VALID_A, 8'd1, 1'b0, 2'd0, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_ZONE, 32'd204, 6'd4, -16'sd32768,
			rfs_pkg::TSTAT_VALID_A, 8'd1, 1'b0, 2'd0, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_ZONE, 32'd205, 6'd5, 16'sd10, 8'd6, 8'd1,
			1'b0, 2'd0, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_ZONE, 32'd206, 6'h3F, 16'sd50,
			rfs_pkg::TSTAT_VALID_B, 8'd3, 1'b1, 2'd0, 8'h00));
		// frame time is 200: an age of exactly the limit is still fresh
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_POLL, 32'd700, 6'd0, 16'sd0, 8'd0, 8'd0,
			1'b0, 2'd0, 8'hEE), rfs_pkg::MODE_RUNNING, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_POLL, 32'd701, 6'd0, 16'sd0, 8'd0, 8'd0,
			1'b0, 2'd0, 8'hEE), rfs_pkg::MODE_ERROR, rfs_pkg::ERR_STALE, 8'h00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_START_OK, 32'hFFFF_FF00, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_BUS_ERR, 32'hFFFF_FF01, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h11), rfs_pkg::MODE_RUNNING, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_BUS_ERR, 32'hFFFF_FF02, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h11), rfs_pkg::MODE_RUNNING, rfs_pkg::ERR_NONE, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_BUS_ERR, 32'hFFFF_FF03, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h22), rfs_pkg::MODE_ERROR, rfs_pkg::ERR_BUS, 8'h22));
		// limit of zero: the first bus error already fails; upper data bits ignored
		dir_tab.push_back(cfg_row(rfs_pkg::CFG_MAX_ERRORS, 16'hFF00));
		dir_tab.push_back(ev_row(rfs_pkg::OP_START_OK, 32'd5000, 6'd0, 16'sd0, 8'd0, 8'd0,
			1'b0, 2'd0, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_BUS_ERR, 32'd5001, 6'd0, 16'sd0, 8'd0, 8'd0,
			1'b0, 2'd0, 8'hA5), rfs_pkg::MODE_ERROR, rfs_pkg::ERR_BUS, 8'hA5));
		// zero stale limit across the 32-bit wrap
		dir_tab.push_back(cfg_row(rfs_pkg::CFG_STALE_LIMIT, 16'h0000));
		dir_tab.push_back(ev_row(rfs_pkg::OP_START_OK, 32'hFFFF_FFF0, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h00));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_POLL, 32'hFFFF_FFF0, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h00), rfs_pkg::MODE_RUNNING, rfs_pkg::ERR_NONE, 8'hA5));
		dir_tab.push_back(pin(ev_row(rfs_pkg::OP_POLL, 32'h0000_0000, 6'd0, 16'sd0, 8'd0,
			8'd0, 1'b0, 2'd0, 8'h00), rfs_pkg::MODE_ERROR, rfs_pkg::ERR_STALE, 8'h00));

		// register settings of the random phases: reset values, both
		// extremes, a zero error limit and a random pair
		stale_set = '{rfs_pkg::STALE_LIMIT_RST, 16'h0000, 16'hFFFF, 16'($urandom),
			16'($urandom_range(1, 2000))};
		err_set = '{{8'h00, rfs_pkg::MAX_ERRORS_RST}, 16'h0001, 16'h5AFF, 16'hA500,
			{8'($urandom), 8'($urandom_range(1, 255))}};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_event(dir_tab[i].ev, dir_tab[i].pinned, dir_tab[i].st,
					dir_tab[i].er, dir_tab[i].api);
			end
		end

		for (int p = 0; p < 5; p++) begin
			settle();
			write_reg(rfs_pkg::CFG_STALE_LIMIT, stale_set[p]);
			write_reg(rfs_pkg::CFG_MAX_ERRORS, err_set[p]);
			run_phase(PHASE_ITEMS);
		end

		// drain, then give any stray status transfer time to show up
		settle();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
